[rtl/core/wav_riff_header_parser_defines.svh]
// ----------------------------------------------------------------------------
// WAV header parser assertion macros
// Shared shorthands for the concurrent checks on the parser's ports.
// ----------------------------------------------------------------------------
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/wrp_pkg.sv]
// ----------------------------------------------------------------------------
// WAV header parser package
// Result type, buffer sizing and result kinds shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wrp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 112;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  data_byte;
    logic        parse_ok;
    logic [3:0]  format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] payload_length;
    logic        is_last;
  } result_t;

  // Results produced by one file byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

[rtl/core/wrp_parse_core.sv]
// ----------------------------------------------------------------------------
// WAV header parser state core
// Holds the parse state and turns one file byte into state updates and results.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_parse_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  output wrp_pkg::push_t      push
);

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_HDR   = 3'd1,
    PH_BODY  = 3'd2,
    PH_PAY   = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [15:0] FMT_PCM  = 16'h0001;
  localparam logic [15:0] FMT_FLT  = 16'h0003;
  localparam logic [15:0] FMT_EXT  = 16'hFFFE;
  localparam logic [31:0] MIN_FILE = 32'd44;
  localparam logic [31:0] EXT_LEN  = 32'd40;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    case (idx)
      4'd0:    magic_byte = 8'h52;
      4'd1:    magic_byte = 8'h49;
      4'd2:    magic_byte = 8'h46;
      4'd3:    magic_byte = 8'h46;
      4'd8:    magic_byte = 8'h57;
      4'd9:    magic_byte = 8'h41;
      4'd10:   magic_byte = 8'h56;
      4'd11:   magic_byte = 8'h45;
      default: magic_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] guid_byte(input logic [3:0] idx);
    case (idx)
      4'd0:    guid_byte = 8'h03;
      4'd6:    guid_byte = 8'h10;
      4'd8:    guid_byte = 8'h80;
      4'd11:   guid_byte = 8'hAA;
      4'd13:   guid_byte = 8'h38;
      4'd14:   guid_byte = 8'h9B;
      4'd15:   guid_byte = 8'h71;
      default: guid_byte = 8'h00;
    endcase
  endfunction

  // Dense format code; an unknown combination keeps the previous code.
  function automatic logic [3:0] fmt_code(
    input logic [15:0] tag,
    input logic [15:0] ch,
    input logic [15:0] bits,
    input logic [31:0] len,
    input logic        guid,
    input logic [3:0]  prev
  );
    logic [15:0] t;
    logic [3:0]  base;
    t    = tag;
    base = 4'd0;
    fmt_code = prev;
    if (tag == FMT_EXT && len >= EXT_LEN) begin
      t = guid ? FMT_FLT : FMT_PCM;
    end
    if (t == FMT_PCM) begin
      if (bits == 16'd8) begin
        base = 4'd1;
      end else if (bits == 16'd16) begin
        base = 4'd5;
      end
      if (base != 4'd0) begin
        if (ch == 16'd1) begin
          fmt_code = base;
        end else if (ch == 16'd2) begin
          fmt_code = base + 4'd1;
        end else if (ch == 16'd4) begin
          fmt_code = base + 4'd2;
        end else if (ch == 16'd6) begin
          fmt_code = base + 4'd3;
        end
      end
    end else if (t == FMT_FLT) begin
      if (ch == 16'd1) begin
        fmt_code = 4'd9;
      end else if (ch == 16'd2) begin
        fmt_code = 4'd10;
      end else if (ch == 16'd6) begin
        fmt_code = 4'd11;
      end
    end
  endfunction

  logic [31:0] file_position, file_position_next;
  phase_t      phase, phase_next;
  logic        magic_good, magic_good_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [32:0] chunk_offset, chunk_offset_next;
  logic        fmt_seen, fmt_seen_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channels, channels_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bits, bits_next;
  logic        guid_match, guid_match_next;
  logic [3:0]  format_reg, format_reg_next;
  logic [31:0] payload_count, payload_count_next;
  logic        data_found, data_found_next;

  logic [2:0]  hdr_off;
  logic [31:0] tag_base, len_base;
  logic [32:0] off_inc, body_total, len_ext;
  logic [3:0]  gidx;
  logic        in_fmt;
  wrp_pkg::result_t data_res, stat_res;
  logic        has_data;

  always_comb begin
    file_position_next = file_position;
    phase_next         = phase;
    magic_good_next    = magic_good;
    chunk_tag_next     = chunk_tag;
    chunk_length_next  = chunk_length;
    chunk_offset_next  = chunk_offset;
    fmt_seen_next      = fmt_seen;
    format_tag_next    = format_tag;
    channels_next      = channels;
    rate_next          = rate;
    bits_next          = bits;
    guid_match_next    = guid_match;
    format_reg_next    = format_reg;
    payload_count_next = payload_count;
    data_found_next    = data_found;

    hdr_off    = chunk_offset[2:0];
    tag_base   = (hdr_off == 3'd0) ? 32'd0 : chunk_tag;
    len_base   = (hdr_off == 3'd0) ? 32'd0 : chunk_length;
    off_inc    = chunk_offset + 33'd1;
    len_ext    = {1'b0, chunk_length};
    body_total = len_ext + {32'd0, chunk_length[0]};
    gidx       = 4'(chunk_offset[5:0] - 6'd24);
    in_fmt     = (chunk_tag == TAG_FMT) && (chunk_offset < len_ext);
    has_data   = 1'b0;

    data_res           = '0;
    data_res.out_kind  = wrp_pkg::KIND_DATA;
    data_res.data_byte = in_byte;

    if (in_valid) begin
      case (phase)
        PH_MAGIC: begin
          if ((file_position < 32'd4 ||
               (file_position >= 32'd8 && file_position < 32'd12)) &&
              magic_byte(file_position[3:0]) != in_byte) begin
            magic_good_next = 1'b0;
          end
          if (file_position >= 32'd11) begin
            phase_next = magic_good_next ? PH_HDR : PH_DONE;
          end
        end
        PH_HDR: begin
          chunk_tag_next    = tag_base;
          chunk_length_next = len_base;
          if (!hdr_off[2]) begin
            chunk_tag_next = {tag_base[23:0], in_byte};
          end else begin
            case (hdr_off[1:0])
              2'd0:    chunk_length_next[7:0]   = in_byte;
              2'd1:    chunk_length_next[15:8]  = in_byte;
              2'd2:    chunk_length_next[23:16] = in_byte;
              default: chunk_length_next[31:24] = in_byte;
            endcase
          end
          chunk_offset_next = {30'd0, hdr_off} + 33'd1;
          if (hdr_off == 3'd7) begin
            // Header complete: open the chunk that it describes.
            chunk_offset_next = '0;
            if (chunk_tag_next == TAG_DATA && fmt_seen) begin
              data_found_next = 1'b1;
              phase_next = (chunk_length_next != 32'd0) ? PH_PAY : PH_DONE;
            end else begin
              if (chunk_tag_next == TAG_FMT) begin
                format_tag_next = '0;
                channels_next   = '0;
                rate_next       = '0;
                bits_next       = '0;
                guid_match_next = 1'b1;
                if (chunk_length_next == 32'd0) begin
                  fmt_seen_next = 1'b1;
                end
              end
              phase_next = (chunk_length_next != 32'd0) ? PH_BODY : PH_HDR;
            end
          end
        end
        PH_BODY: begin
          if (in_fmt) begin
            if (chunk_offset < 33'd2) begin
              if (chunk_offset[0]) format_tag_next[15:8] = in_byte;
              else                 format_tag_next[7:0]  = in_byte;
            end else if (chunk_offset < 33'd4) begin
              if (chunk_offset[0]) channels_next[15:8] = in_byte;
              else                 channels_next[7:0]  = in_byte;
            end else if (chunk_offset < 33'd8) begin
              case (chunk_offset[1:0])
                2'd0:    rate_next[7:0]   = in_byte;
                2'd1:    rate_next[15:8]  = in_byte;
                2'd2:    rate_next[23:16] = in_byte;
                default: rate_next[31:24] = in_byte;
              endcase
            end else if (chunk_offset == 33'd14 || chunk_offset == 33'd15) begin
              if (chunk_offset[0]) bits_next[15:8] = in_byte;
              else                 bits_next[7:0]  = in_byte;
            end else if (chunk_offset >= 33'd24 && chunk_offset < 33'd40) begin
              if (guid_byte(gidx) != in_byte) begin
                guid_match_next = 1'b0;
              end
            end
          end
          // The format code sees the fields including this byte.
          if (chunk_tag == TAG_FMT && off_inc == len_ext) begin
            format_reg_next = fmt_code(format_tag_next, channels_next, bits_next,
                                       chunk_length, guid_match_next, format_reg);
            fmt_seen_next   = 1'b1;
          end
          if (off_inc >= body_total) begin
            chunk_offset_next = '0;
            phase_next        = PH_HDR;
          end else begin
            chunk_offset_next = off_inc;
          end
        end
        PH_PAY: begin
          has_data = 1'b1;
          if (payload_count != '1) begin
            payload_count_next = payload_count + 32'd1;
          end
          chunk_offset_next = off_inc;
          if (off_inc >= len_ext) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (file_position != '1) begin
        file_position_next = file_position + 32'd1;
      end
    end

    stat_res                = '0;
    stat_res.out_kind       = wrp_pkg::KIND_STATUS;
    stat_res.parse_ok       = magic_good_next && data_found_next &&
                              (file_position_next >= MIN_FILE);
    stat_res.format_code    = format_reg_next;
    stat_res.channel_count  = channels_next;
    stat_res.sample_rate    = rate_next;
    stat_res.sample_bits    = bits_next;
    stat_res.payload_length = payload_count_next;
    stat_res.is_last        = 1'b1;

    push.count  = {1'b0, has_data} + {1'b0, in_valid && in_last};
    push.first  = has_data ? data_res : stat_res;
    push.second = stat_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_valid && in_last)) begin
      // End of file returns the parser to its reset state.
      file_position <= '0;
      phase         <= PH_MAGIC;
      magic_good    <= 1'b1;
      chunk_tag     <= '0;
      chunk_length  <= '0;
      chunk_offset  <= '0;
      fmt_seen      <= 1'b0;
      format_tag    <= '0;
      channels      <= '0;
      rate          <= '0;
      bits          <= '0;
      guid_match    <= 1'b1;
      format_reg    <= '0;
      payload_count <= '0;
      data_found    <= 1'b0;
    end else begin
      file_position <= file_position_next;
      phase         <= phase_next;
      magic_good    <= magic_good_next;
      chunk_tag     <= chunk_tag_next;
      chunk_length  <= chunk_length_next;
      chunk_offset  <= chunk_offset_next;
      fmt_seen      <= fmt_seen_next;
      format_tag    <= format_tag_next;
      channels      <= channels_next;
      rate          <= rate_next;
      bits          <= bits_next;
      guid_match    <= guid_match_next;
      format_reg    <= format_reg_next;
      payload_count <= payload_count_next;
      data_found    <= data_found_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/wrp_result_fifo.sv]
// ----------------------------------------------------------------------------
// WAV header parser result buffer
// Small queue that takes up to two results per cycle and drains one.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_result_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire wrp_pkg::push_t   push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wrp_pkg::result_t      out_res
);

  wrp_pkg::result_t mem [wrp_pkg::FIFO_DEPTH];

  logic [wrp_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [wrp_pkg::FIFO_CW-1:0] count;
  logic                        pop;
  logic [wrp_pkg::FIFO_AW-1:0] wr_ptr_1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign wr_ptr_1  = wr_ptr + {{(wrp_pkg::FIFO_AW-1){1'b0}}, 1'b1};
  // Two free entries are needed because one byte can yield two results.
  assign room      = (count <= wrp_pkg::FIFO_CW'(wrp_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wrp_pkg::FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + {{(wrp_pkg::FIFO_AW-1){1'b0}}, 1'b1};
      end
      count <= count + wrp_pkg::FIFO_CW'(push.count) - wrp_pkg::FIFO_CW'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/core/wav_riff_header_parser.sv]
// ----------------------------------------------------------------------------
// WAV header parser
// Streams a RIFF/WAVE file byte by byte, passes audio bytes on, reports status.
// ----------------------------------------------------------------------------
// The parser takes one file byte per cycle on the slave side while its result
// buffer has room. Each byte goes through an input register and a single pass
// of state update logic, and its results land in a four-entry result buffer.
// Bytes of the first data chunk after a fmt chunk come out as data results;
// the byte marked tlast also yields a status result carrying the parse verdict
// and the fmt fields, after which the parser is back in its reset state for
// the next file. Throughput is one byte per cycle, set by the one output
// transfer per cycle that drains the result buffer while the output does not
// stall; a final byte that is also a data byte makes two results and so costs
// one extra output transfer.
`default_nettype none

module wav_riff_header_parser (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [wrp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] in_byte
  input  wire logic                              s_tlast,   // in_last
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [7:0] data_byte, [8] parse_ok, [12:9] format_code, [28:13] channel_count,
  // [60:29] sample_rate, [76:61] sample_bits, [108:77] payload_length, rest 0
  output logic [wrp_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   m_tuser,   // out_kind
  output logic                                   m_tlast    // is_last
);

  logic             stg_valid;
  logic [7:0]       stg_byte;
  logic             stg_last;
  logic             room;
  logic             advance;
  wrp_pkg::push_t   push;
  wrp_pkg::result_t out_res;

  assign advance  = stg_valid && room;
  assign s_tready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stg_byte <= s_tdata[7:0];
      stg_last <= s_tlast;
    end
  end

  wrp_parse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (advance),
    .in_byte  (stg_byte),
    .in_last  (stg_last),
    .push     (push)
  );

  wrp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res.payload_length, out_res.sample_bits,
                    out_res.sample_rate, out_res.channel_count,
                    out_res.format_code, out_res.parse_ok, out_res.data_byte};
  assign m_tuser = out_res.out_kind;
  assign m_tlast = out_res.is_last;

endmodule

`default_nettype wire

[rtl/core/wrp_checker.sv]
// ----------------------------------------------------------------------------
// WAV header parser port checker
// Checks the result stream of the parser as seen at its ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_riff_header_parser_defines.svh"

module wrp_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [wrp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input wire logic                               m_tuser,
  input wire logic                               m_tlast
);

  logic is_status;
  logic is_data;
  assign is_status = m_tvalid && (m_tuser == wrp_pkg::KIND_STATUS);
  assign is_data   = m_tvalid && (m_tuser == wrp_pkg::KIND_DATA);

  // A stalled result must not change.
  `WRP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}), "stalled result changed")

  // Only the status result closes a file.
  `WRP_ASSERT_SAME(a_last_is_status, m_tvalid, m_tlast == is_status, "tlast does not match the kind")

  // Data results carry nothing but the audio byte.
  `WRP_ASSERT_SAME(a_data_clean, is_data, m_tdata[111:8] == '0, "data result carries status fields")

  // Status results have no data byte and a defined format code.
  `WRP_ASSERT_SAME(a_status_fields, is_status, m_tdata[7:0] == 8'h00 && m_tdata[12:9] <= 4'd11, "bad status result")

  // An empty result buffer never holds off the input.
  `WRP_ASSERT_SAME(a_in_open, s_tvalid && !m_tvalid, s_tready, "input blocked while buffer empty")

endmodule

bind wav_riff_header_parser wrp_checker u_wrp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/sv/tb_wav_riff_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams a directed table and then randomly built WAV files into the parser.
// Every output transfer is checked against a byte-level model of the parser,
// under random idling on both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------

module tb_wav_riff_header_parser;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [15:0] WTAG_PCM        = 16'h0001;
  localparam logic [15:0] WTAG_FLOAT      = 16'h0003;
  localparam logic [15:0] WTAG_EXTENSIBLE = 16'hFFFE;

  localparam logic [3:0] CODE_PCM8_MONO    = 4'd1;
  localparam logic [3:0] CODE_PCM16_MONO   = 4'd5;
  localparam logic [3:0] CODE_FLOAT_MONO   = 4'd9;
  localparam logic [3:0] CODE_FLOAT_STEREO = 4'd10;
  localparam logic [3:0] CODE_FLOAT_51     = 4'd11;

  // IEEE float sub-format GUID, first byte in the lowest bits.
  localparam logic [127:0] FLOAT_GUID = 128'h719b3800_aa000080_00100000_00000003;

  localparam int RANDOM_BYTES = 2000;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [2:0] {
    ST_MAGIC, ST_CHUNK_HDR, ST_CHUNK_BODY, ST_PAYLOAD, ST_IGNORE
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       given;
  } stim_row_t;

  // The short files of the directed table fail to pass and report a status with all fields zero.
  localparam wrp_pkg::result_t EMPTY_STATUS = {wrp_pkg::KIND_STATUS, 109'd0, 1'b1};

  localparam int DIR_ROWS = 30;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    {8'h00, 1'b1, 1'b1},  // one-byte files right after reset
    {8'hFF, 1'b1, 1'b1},
    {8'h52, 1'b0, 1'b0}, {8'h49, 1'b0, 1'b0}, {8'h46, 1'b0, 1'b0}, {8'h46, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0}, {8'h80, 1'b0, 1'b0}, {8'h7F, 1'b0, 1'b0},
    {8'h57, 1'b0, 1'b0}, {8'h41, 1'b0, 1'b0}, {8'h56, 1'b0, 1'b0}, {8'h45, 1'b0, 1'b0},
    {8'h66, 1'b0, 1'b0}, {8'h6D, 1'b0, 1'b0}, {8'h74, 1'b0, 1'b0}, {8'h20, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
    {8'h64, 1'b0, 1'b0}, {8'h61, 1'b0, 1'b0}, {8'h74, 1'b0, 1'b0}, {8'h61, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
    {8'h00, 1'b1, 1'b1}   // empty data chunk, but only 28 bytes long
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [wrp_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [wrp_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;

  wav_riff_header_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Parser model state.
  logic [31:0]  pos;
  parse_phase_e phase;
  logic         magic_ok;
  logic [31:0]  ctag;
  logic [31:0]  clen;
  logic [32:0]  coff;
  logic         fmt_done;
  logic [15:0]  wtag;
  logic [15:0]  chans;
  logic [31:0]  rate;
  logic [15:0]  sbits;
  logic         guid_ok;
  logic [3:0]   fcode;
  logic [31:0]  pay_cnt;
  logic         data_seen;

  wrp_pkg::result_t step_results[$];
  wrp_pkg::result_t awaited_results[$];
  logic [7:0]       file_q[$];

  int  error_count = 0;
  int  bytes_sent = 0;
  int  files_sent = 0;
  int  data_checked = 0;
  int  status_checked = 0;
  int  ok_checked = 0;
  int  hold_left = 0;
  bit  hold_ask = 1'b0;
  bit  steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_parser();
    pos = '0;
    phase = ST_MAGIC;
    magic_ok = 1'b1;
    ctag = '0;
    clen = '0;
    coff = '0;
    fmt_done = 1'b0;
    wtag = '0;
    chans = '0;
    rate = '0;
    sbits = '0;
    guid_ok = 1'b1;
    fcode = '0;
    pay_cnt = '0;
    data_seen = 1'b0;
  endfunction

  // Body length plus the pad byte of an odd chunk, over the full 32-bit range.
  function automatic logic [32:0] chunk_span();
    return {1'b0, clen} + {32'd0, clen[0]};
  endfunction

  function automatic void close_fmt();
    logic [15:0] t;
    logic [3:0]  base;
    t = wtag;
    if (t == WTAG_EXTENSIBLE && clen >= 32'd40) t = guid_ok ? WTAG_FLOAT : WTAG_PCM;
    if (t == WTAG_PCM && (sbits == 16'd8 || sbits == 16'd16)) begin
      base = (sbits == 16'd8) ? CODE_PCM8_MONO : CODE_PCM16_MONO;
      case (chans)
        16'd1: fcode = base;
        16'd2: fcode = base + 4'd1;
        16'd4: fcode = base + 4'd2;
        16'd6: fcode = base + 4'd3;
        default: ;
      endcase
    end else if (t == WTAG_FLOAT) begin
      case (chans)
        16'd1: fcode = CODE_FLOAT_MONO;
        16'd2: fcode = CODE_FLOAT_STEREO;
        16'd6: fcode = CODE_FLOAT_51;
        default: ;
      endcase
    end
    fmt_done = 1'b1;
  endfunction

  function automatic void open_chunk();
    coff = '0;
    if (ctag == TAG_DATA && fmt_done) begin
      data_seen = 1'b1;
      phase = (clen != 0) ? ST_PAYLOAD : ST_IGNORE;
      return;
    end
    if (ctag == TAG_FMT) begin
      wtag = '0;
      chans = '0;
      rate = '0;
      sbits = '0;
      guid_ok = 1'b1;
      if (clen == 0) close_fmt();
    end
    phase = (chunk_span() != 0) ? ST_CHUNK_BODY : ST_CHUNK_HDR;
  endfunction

  function automatic void body_byte(logic [7:0] b);
    logic [32:0] off;
    int          idx;
    off = coff;
    idx = int'(off[5:0]);
    // Fields are cleared at the chunk header, so each byte lands by plain assignment.
    if (ctag == TAG_FMT && off < {1'b0, clen}) begin
      if (off < 2) wtag[8*idx +: 8] = b;
      else if (off < 4) chans[8*(idx-2) +: 8] = b;
      else if (off < 8) rate[8*(idx-4) +: 8] = b;
      else if (off == 14 || off == 15) sbits[8*(idx-14) +: 8] = b;
      else if (off >= 24 && off < 40) begin
        if (FLOAT_GUID[8*(idx-24) +: 8] != b) guid_ok = 1'b0;
      end
    end
    coff = off + 33'd1;
    if (ctag == TAG_FMT && coff == {1'b0, clen}) close_fmt();
    if (coff >= chunk_span()) begin
      coff = '0;
      phase = ST_CHUNK_HDR;
    end
  endfunction

  // Works out the results of one accepted file byte into step_results.
  function automatic void parse_byte(logic [7:0] b, logic last);
    wrp_pkg::result_t r;
    int               idx;
    case (phase)
      ST_MAGIC: begin
        idx = int'(pos[3:0]);
        if (idx < 4) begin
          if (TAG_RIFF[8*(3-idx) +: 8] != b) magic_ok = 1'b0;
        end else if (idx >= 8) begin
          if (TAG_WAVE[8*(11-idx) +: 8] != b) magic_ok = 1'b0;
        end
        if (idx >= 11) phase = magic_ok ? ST_CHUNK_HDR : ST_IGNORE;
      end
      ST_CHUNK_HDR: begin
        idx = int'(coff[2:0]);
        if (idx == 0) begin
          ctag = '0;
          clen = '0;
        end
        if (idx < 4) ctag = {ctag[23:0], b};
        else clen[8*(idx-4) +: 8] = b;
        coff = 33'(idx + 1);
        if (coff == 33'd8) open_chunk();
      end
      ST_CHUNK_BODY: body_byte(b);
      ST_PAYLOAD: begin
        r = '0;
        r.out_kind = wrp_pkg::KIND_DATA;
        r.data_byte = b;
        step_results.push_back(r);
        if (pay_cnt != '1) pay_cnt = pay_cnt + 32'd1;
        coff = coff + 33'd1;
        if (coff >= {1'b0, clen}) phase = ST_IGNORE;
      end
      default: ;
    endcase
    if (pos != '1) pos = pos + 32'd1;
    if (last) begin
      r = '0;
      r.out_kind = wrp_pkg::KIND_STATUS;
      r.parse_ok = magic_ok && data_seen && pos >= 32'd44;
      r.format_code = fcode;
      r.channel_count = chans;
      r.sample_rate = rate;
      r.sample_bits = sbits;
      r.payload_length = pay_cnt;
      r.is_last = 1'b1;
      step_results.push_back(r);
      clear_parser();
    end
  endfunction

  function automatic void put_tag(logic [31:0] t);
    file_q.push_back(t[31:24]);
    file_q.push_back(t[23:16]);
    file_q.push_back(t[15:8]);
    file_q.push_back(t[7:0]);
  endfunction

  function automatic void put_u32(logic [31:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
    file_q.push_back(v[23:16]);
    file_q.push_back(v[31:24]);
  endfunction

  // A chunk whose body is random bytes, with its pad byte when the length is odd.
  function automatic void put_random_chunk(logic [31:0] tag, int n);
    put_tag(tag);
    put_u32(n);
    repeat (n + (n % 2)) file_q.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt_chunk();
    logic [7:0]  fb [48];
    logic [15:0] t16;
    logic [15:0] c16;
    logic [15:0] b16;
    int          k;
    int          flen;
    k = $urandom_range(99);
    if (k < 40) flen = 16;
    else if (k < 55) flen = 18;
    else if (k < 80) flen = 40;
    else if (k < 95) flen = $urandom_range(0, 15);
    else flen = $urandom_range(41, 47);
    foreach (fb[i]) fb[i] = 8'($urandom);
    case ($urandom_range(3))
      0: t16 = WTAG_PCM;
      1: t16 = WTAG_FLOAT;
      2: t16 = WTAG_EXTENSIBLE;
      default: t16 = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0: c16 = 16'd1;
      1: c16 = 16'd2;
      2: c16 = 16'd4;
      3: c16 = 16'd6;
      4: c16 = 16'($urandom_range(0, 8));
      default: c16 = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: b16 = 16'd8;
      1: b16 = 16'd16;
      2: b16 = 16'd24;
      default: b16 = 16'($urandom);
    endcase
    fb[0] = t16[7:0];
    fb[1] = t16[15:8];
    fb[2] = c16[7:0];
    fb[3] = c16[15:8];
    fb[14] = b16[7:0];
    fb[15] = b16[15:8];
    k = $urandom_range(3);
    if (k != 3) begin
      for (int i = 0; i < 16; i++) fb[24+i] = FLOAT_GUID[8*i +: 8];
      if (k == 2) fb[24 + $urandom_range(15)] ^= 8'(1 << $urandom_range(7));
    end
    put_tag(TAG_FMT);
    put_u32(flen);
    for (int i = 0; i < flen; i++) file_q.push_back(fb[i]);
    if (flen % 2 == 1) file_q.push_back(8'($urandom));
  endfunction

  // Mostly well-formed files with random content; the rest is noise, broken
  // tags, truncation and chunks long enough to swallow the rest of the file.
  function automatic void build_file();
    int pick;
    int n;
    int i;
    file_q.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      n = $urandom_range(1, 20);
      repeat (n) file_q.push_back(8'($urandom));
      return;
    end
    put_tag(TAG_RIFF);
    put_u32($urandom);
    put_tag(TAG_WAVE);
    if (pick < 15) begin
      i = $urandom_range(7);
      if (i >= 4) i = i + 4;
      file_q[i] ^= 8'(1 << $urandom_range(7));
    end
    if ($urandom_range(99) < 25) put_random_chunk($urandom, $urandom_range(0, 9));
    if ($urandom_range(99) < 15) put_random_chunk(TAG_DATA, $urandom_range(0, 5));
    put_fmt_chunk();
    if ($urandom_range(99) < 20) put_fmt_chunk();
    if ($urandom_range(99) < 4) begin
      put_tag($urandom);
      put_u32(32'hFFFF_FFFF);
      repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom));
    end else if ($urandom_range(99) < 5) begin
      put_tag(TAG_DATA);
      put_u32(32'hFFFF_FFFF);
      repeat ($urandom_range(0, 20)) file_q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 24);
      put_tag(TAG_DATA);
      put_u32(n);
      repeat (n) file_q.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, file_q.size());
      while (file_q.size() > n) void'(file_q.pop_back());
    end
  endfunction

  // Offers one byte until the transfer happens, then queues what it should cause.
  task automatic push_byte(input logic [7:0] b, input logic last, input logic given);
    logic done;
    while (!steady && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = s_tready;
      @(posedge clk);
    end
    bytes_sent++;
    step_results.delete();
    parse_byte(b, last);
    if (given) awaited_results.push_back(EMPTY_STATUS);
    else foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    wrp_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch("unexpected result, low tdata", m_tdata[31:0], 32'd0);
      return;
    end
    want = awaited_results.pop_front();
    if (m_tuser !== want.out_kind)
      note_mismatch("out_kind", 32'(m_tuser), 32'(want.out_kind));
    if (m_tdata[7:0] !== want.data_byte)
      note_mismatch("data_byte", 32'(m_tdata[7:0]), 32'(want.data_byte));
    if (m_tdata[8] !== want.parse_ok)
      note_mismatch("parse_ok", 32'(m_tdata[8]), 32'(want.parse_ok));
    if (m_tdata[12:9] !== want.format_code)
      note_mismatch("format_code", 32'(m_tdata[12:9]), 32'(want.format_code));
    if (m_tdata[28:13] !== want.channel_count)
      note_mismatch("channel_count", 32'(m_tdata[28:13]), 32'(want.channel_count));
    if (m_tdata[60:29] !== want.sample_rate)
      note_mismatch("sample_rate", m_tdata[60:29], want.sample_rate);
    if (m_tdata[76:61] !== want.sample_bits)
      note_mismatch("sample_bits", 32'(m_tdata[76:61]), 32'(want.sample_bits));
    if (m_tdata[108:77] !== want.payload_length)
      note_mismatch("payload_length", m_tdata[108:77], want.payload_length);
    if (m_tdata[111:109] !== 3'd0)
      note_mismatch("tdata padding", 32'(m_tdata[111:109]), 32'd0);
    if (m_tlast !== want.is_last)
      note_mismatch("is_last", 32'(m_tlast), 32'(want.is_last));
    if (want.out_kind == wrp_pkg::KIND_STATUS) begin
      status_checked++;
      if (want.parse_ok) ok_checked++;
    end else begin
      data_checked++;
    end
  endtask

  // Output side: signals are sampled at the falling edge, so a transfer seen
  // there is the one that completes at the next rising edge.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) check_result();
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      push_byte(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].given);

    while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
      build_file();
      if (files_sent == 4) hold_ask = 1'b1;
      if (files_sent == 9) begin
        go_quiet();
        wait_drained();
      end
      steady = (files_sent >= 14 && files_sent < 20);
      foreach (file_q[k]) push_byte(file_q[k], k == file_q.size() - 1, 1'b0);
      files_sent++;
    end
    steady = 1'b0;
    go_quiet();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("%0d bytes in %0d random files plus a directed table were streamed",
             bytes_sent, files_sent);
    $display("%0d payload bytes and %0d file reports checked, %0d of them parsed ok",
             data_checked, status_checked, ok_checked);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
